### design/msp_v1_v2_frame_parser_top_assert.svh
// ----------------------------------------------------------------------------
// MSP frame parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef MSP_V1_V2_FRAME_PARSER_TOP_ASSERT_SVH
`define MSP_V1_V2_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("msp parser check failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("msp parser check failed");

`endif

### design/msp_pkg.sv
// ----------------------------------------------------------------------------
// MSP frame parser package
// Result kinds, register indexes, result record and the CRC-8 DVB-S2 step.
// ----------------------------------------------------------------------------
package msp_pkg;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_V1_MAGIC   = 2'd1;
    localparam logic [1:0] REG_V2_MAGIC   = 2'd2;

    localparam logic [7:0] START_BYTE_RST = 8'd36;
    localparam logic [7:0] V1_MAGIC_RST   = 8'd77;
    localparam logic [7:0] V2_MAGIC_RST   = 8'd88;
    localparam logic [7:0] DIRECTION_BYTE = 8'h3E;
    localparam logic [7:0] V2_FLAG_VALUE  = 8'h00;
    localparam logic [7:0] CRC8_POLY      = 8'hD5;

    typedef struct packed {
        t_kind       kind;
        logic        version;
        logic [15:0] command;
        logic [15:0] frame_length;
        logic [15:0] byte_index;
        logic [7:0]  payload_byte;
    } t_result;

    function automatic logic [7:0] crc8_dvb_s2(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### design/msp_rx_if.sv
// ----------------------------------------------------------------------------
// MSP received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ----------------------------------------------------------------------------
interface msp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/msp_res_if.sv
// ----------------------------------------------------------------------------
// MSP parser result channel
// Valid/ready channel carrying one payload byte or frame verdict per
// transaction.
// ----------------------------------------------------------------------------
interface msp_res_if;
    import msp_pkg::*;

    logic        valid;
    logic        ready;
    t_kind       kind;
    logic        version;
    logic [15:0] command;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;

    modport source (output valid, output kind, output version, output command,
                    output frame_length, output byte_index, output payload_byte,
                    input ready);
    modport sink   (input valid, input kind, input version, input command,
                    input frame_length, input byte_index, input payload_byte,
                    output ready);
endinterface

### design/msp_v1_v2_frame_parser_top.sv
// ----------------------------------------------------------------------------
// MSP v1/v2 frame parser
// Recognizes MSP v1 (XOR check) and v2 (CRC-8 DVB-S2 check) frames in a byte
// stream, emits each payload byte with its index and one good/bad verdict per
// frame.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle while the skid register is
// empty. The parser state and the running check update in the cycle a byte
// is accepted; any result it causes is registered into the output register,
// or into the skid register if that is full. This two-entry output queue
// keeps input flowing while the consumer stalls for one result; input ready
// drops only while the skid register is occupied. Bad-verdict frames are for
// the consumer to drop; payload bytes are not buffered, lengths not capped.

`include "msp_v1_v2_frame_parser_top_assert.svh"

module msp_v1_v2_frame_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    msp_rx_if.sink     i_rx,
    msp_res_if.source  o_res
);
    import msp_pkg::*;

    typedef enum logic [3:0] {
        ST_START, ST_HEADER, ST_DIRECTION, ST_V1_LEN, ST_V1_CMD, ST_V1_DATA,
        ST_V2_FLAG, ST_V2_CMD_LO, ST_V2_CMD_HI, ST_V2_LEN_LO, ST_V2_LEN_HI,
        ST_V2_DATA, ST_CHECK
    } t_state;

    logic [7:0]  r_start_byte, r_v1_magic, r_v2_magic;

    t_state      r_state, n_state;
    logic        r_is_v2, n_is_v2;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_chk, n_chk;
    logic [15:0] r_cnt, n_cnt;

    t_result     r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid;
    logic        res_valid;
    logic        acc, pop, push;
    logic [7:0]  d;

    assign d      = i_rx.rx_byte;
    assign acc    = i_rx.valid && i_rx.ready;
    assign pop    = r_out_valid && o_res.ready;
    assign push   = acc && res_valid;

    assign i_rx.ready         = !r_skid_valid;
    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.version      = r_out.version;
    assign o_res.command      = r_out.command;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.payload_byte = r_out.payload_byte;

    always_comb begin
        n_state   = r_state;
        n_is_v2   = r_is_v2;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_chk     = r_chk;
        n_cnt     = r_cnt;
        res_valid = 1'b0;
        res       = '{kind: KIND_DATA, version: r_is_v2, command: r_cmd,
                      frame_length: r_len, byte_index: r_cnt, payload_byte: d};
        unique case (r_state)
            ST_START: begin
                if (d == r_start_byte) n_state = ST_HEADER;
            end
            ST_HEADER: begin
                priority if (d == r_v1_magic) begin
                    n_is_v2 = 1'b0;
                    n_state = ST_DIRECTION;
                end else if (d == r_v2_magic) begin
                    n_is_v2 = 1'b1;
                    n_state = ST_DIRECTION;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_DIRECTION: begin
                if (d == DIRECTION_BYTE) n_state = r_is_v2 ? ST_V2_FLAG : ST_V1_LEN;
                else                     n_state = ST_START;
            end
            ST_V1_LEN: begin
                n_chk   = d;
                n_len   = {8'd0, d};
                n_state = ST_V1_CMD;
            end
            ST_V1_CMD: begin
                n_chk   = r_chk ^ d;
                n_cmd   = {8'd0, d};
                n_cnt   = '0;
                n_state = (r_len == '0) ? ST_CHECK : ST_V1_DATA;
            end
            ST_V1_DATA, ST_V2_DATA: begin
                res_valid = 1'b1;
                n_chk     = (r_state == ST_V1_DATA) ? (r_chk ^ d) : crc8_dvb_s2(r_chk, d);
                n_cnt     = r_cnt + 16'd1;
                if (n_cnt == r_len) n_state = ST_CHECK;
            end
            ST_V2_FLAG: begin
                if (d == V2_FLAG_VALUE) begin
                    n_chk   = crc8_dvb_s2(8'd0, d);
                    n_state = ST_V2_CMD_LO;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_V2_CMD_LO: begin
                n_cmd   = {8'd0, d};
                n_chk   = crc8_dvb_s2(r_chk, d);
                n_state = ST_V2_CMD_HI;
            end
            ST_V2_CMD_HI: begin
                n_cmd   = r_cmd | {d, 8'd0};
                n_chk   = crc8_dvb_s2(r_chk, d);
                n_state = ST_V2_LEN_LO;
            end
            ST_V2_LEN_LO: begin
                n_len   = {8'd0, d};
                n_chk   = crc8_dvb_s2(r_chk, d);
                n_state = ST_V2_LEN_HI;
            end
            ST_V2_LEN_HI: begin
                n_len   = r_len | {d, 8'd0};
                n_chk   = crc8_dvb_s2(r_chk, d);
                n_cnt   = '0;
                n_state = (n_len == '0) ? ST_CHECK : ST_V2_DATA;
            end
            ST_CHECK: begin
                res_valid        = 1'b1;
                res.kind         = (d == r_chk) ? KIND_GOOD : KIND_BAD;
                res.byte_index   = '0;
                res.payload_byte = '0;
                n_state          = ST_START;
            end
            default: begin
                n_state = ST_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_v1_magic   <= V1_MAGIC_RST;
            r_v2_magic   <= V2_MAGIC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_BYTE: r_start_byte <= i_cfg_wdata;
                REG_V1_MAGIC:   r_v1_magic   <= i_cfg_wdata;
                REG_V2_MAGIC:   r_v2_magic   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_is_v2 <= 1'b0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_chk   <= '0;
            r_cnt   <= '0;
        end else if (acc) begin
            r_state <= n_state;
            r_is_v2 <= n_is_v2;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_chk   <= n_chk;
            r_cnt   <= n_cnt;
        end
    end

    // output register + skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (!r_out_valid) r_out_valid  <= 1'b1;
            else              r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (push)    r_out <= res;
        end else if (push) begin
            if (!r_out_valid) r_out  <= res;
            else              r_skid <= res;
        end
    end

    `MSP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MSP_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n,
        (r_state == ST_V1_DATA || r_state == ST_V2_DATA), (r_cnt < r_len))
    `MSP_ASSERT_NEXT(a_check_ends_frame, i_clk, i_rst_n,
        (acc && r_state == ST_CHECK), (r_state == ST_START))
    `MSP_ASSERT_NOW(a_verdict_zero_fields, i_clk, i_rst_n,
        (r_out_valid && r_out.kind != KIND_DATA),
        (r_out.byte_index == '0 && r_out.payload_byte == '0))

endmodule
